FILE: src/fmbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fmbs_pkg;

  // store geometry
  localparam int BwtLen  = 65536;
  localparam int Stride  = 64;
  localparam int Rows    = BwtLen / Stride;
  localparam int PosW    = $clog2(BwtLen);
  localparam int LaneW   = $clog2(Stride);
  localparam int RowW    = PosW - LaneW;
  localparam int CntW    = PosW + 1;
  localparam int SymW    = 3;
  localparam int CkFldW  = 16;
  localparam int CkW     = 4 * CkFldW;

  // symbol codes
  localparam logic [SymW-1:0] SymOther = 3'd4;

  // op codes
  localparam logic OpLoad   = 1'b0;
  localparam logic OpSearch = 1'b1;

  // status codes
  localparam logic [1:0] StMatch   = 2'd0;
  localparam logic [1:0] StNoOcc   = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ1,
    S_WAIT,
    S_CAP0,
    S_CAP1
  } state_e;

  // store write port
  typedef struct packed {
    logic            en;
    logic [PosW-1:0] pos;
    logic [SymW-1:0] sym;
    logic [CkW-1:0]  ckpt;
  } wr_t;

  // rank request: count of code c over positions below n
  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] n;
    logic [1:0]      c;
  } rank_req_t;

endpackage
`default_nettype wire

FILE: src/fmbs_store.sv
`timescale 1ns / 1ps
`default_nettype none
module fmbs_store (
  input  logic                       clk_i,
  input  fmbs_pkg::wr_t              wr_i,
  input  fmbs_pkg::rank_req_t        req_i,
  output logic [fmbs_pkg::CntW-1:0]  rank_o
);
  import fmbs_pkg::*;

  // one row per checkpoint block: symbols and counts before the block
  logic [SymW-1:0]   bwt_mem  [Rows][Stride];
  logic [CkW-1:0]    ckpt_mem [Rows];

  logic [SymW-1:0]   row_q [Stride];
  logic [CkW-1:0]    ck_q;
  logic [LaneW-1:0]  lanes_q;
  logic [1:0]        c_q;
  logic [Stride-1:0] hit_d, hit_q;
  logic [CkFldW-1:0] base_q;
  logic [CntW-1:0]   rank_q;

  // write port and registered row read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      bwt_mem[wr_i.pos[PosW-1:LaneW]][wr_i.pos[LaneW-1:0]] <= wr_i.sym;
      if (wr_i.pos[LaneW-1:0] == '0) begin
        ckpt_mem[wr_i.pos[PosW-1:LaneW]] <= wr_i.ckpt;
      end
    end
    if (req_i.valid) begin
      row_q   <= bwt_mem[req_i.n[PosW-1:LaneW]];
      ck_q    <= ckpt_mem[req_i.n[PosW-1:LaneW]];
      lanes_q <= req_i.n[LaneW-1:0];
      c_q     <= req_i.c;
    end
  end

  // match lanes below the cut
  always_comb begin
    for (int i = 0; i < Stride; i++) begin
      hit_d[i] = (LaneW'(i) < lanes_q) && (row_q[i] == {1'b0, c_q});
    end
  end

  // compare stage, then count stage
  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    base_q <= ck_q[c_q*CkFldW +: CkFldW];
    rank_q <= CntW'(base_q) + CntW'($countones(hit_q));
  end

  assign rank_o = rank_q;

endmodule
`default_nettype wire

FILE: src/fm_index_backward_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Beat contents (low bit up)
// s_axis    in   tdata: symbol[2:0], zero pad; tuser: op, pattern_start
// m_axis    out  tdata: interval_low[15:0], interval_high[15:0], status[1:0], pad
// cfg       in   cfg_we_i / cfg_wdata_i: primary_position
//
// A narrowing search step makes two rank reads of the block memory,
// each through read, compare and count stages. A starting, failed or
// invalid step answers from idle without a rank read. Input is taken only
// in idle with the output register free or emptying. Reset clears totals,
// load position, interval and status; memory contents are rewritten by loads.
module fm_index_backward_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // symbol[2:0], zero pad
  input  logic [1:0]  s_axis_tuser,   // op, pattern_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // interval_low, interval_high, status, pad
);
  import fmbs_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   tot_q [5];
  logic [CntW-1:0]   tot_d [5];
  logic [CntW-1:0]   lp_q, lp_d;
  logic [PosW-1:0]   low_q, low_d, high_q, high_d, pp_q;
  logic [1:0]        fail_q, fail_d;
  logic [1:0]        c_q, c_d;
  logic [PosW-1:0]   n1_q, n1_d;
  logic              use0_q, use0_d, use1_q, use1_d;
  logic [CntW-1:0]   r0_q, r0_d;
  logic              mv_q, mv_d;
  logic [PosW-1:0]   ml_q, ml_d, mh_q, mh_d;
  logic [1:0]        ms_q, ms_d;

  logic [PosW-1:0]   base [5];
  wr_t               wr;
  rank_req_t         req;
  logic [CntW-1:0]   rank;
  logic              acc;
  logic [SymW-1:0]   sym, sym4;
  logic [CntW-1:0]   x0, x1, r0f, r1f, lo1, hi1;
  logic              finish;

  fmbs_store u_store (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .req_i  (req),
    .rank_o (rank)
  );

  // bucket bases from totals
  always_comb begin
    base[0] = '0;
    base[1] = tot_q[0][PosW-1:0] - PosW'(1);
    for (int k = 2; k < 5; k++) begin
      base[k] = base[k-1] + tot_q[k-1][PosW-1:0];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && (!mv_q || m_axis_tready);
  assign acc  = s_axis_tvalid && s_axis_tready;
  assign sym  = s_axis_tdata[SymW-1:0];
  assign sym4 = (sym > SymOther) ? SymOther : sym;
  assign x0   = {1'b0, low_q} + CntW'(1);
  assign x1   = {1'b0, high_q} + CntW'(2);
  assign lo1  = {1'b0, low_q} + CntW'(1);
  assign hi1  = {1'b0, high_q} + CntW'(1);

  // next state and datapath
  always_comb begin
    state_d = state_q;
    tot_d   = tot_q;
    lp_d    = lp_q;
    low_d   = low_q;
    high_d  = high_q;
    fail_d  = fail_q;
    c_d     = c_q;
    n1_d    = n1_q;
    use0_d  = use0_q;
    use1_d  = use1_q;
    r0_d    = r0_q;
    mv_d    = mv_q && !m_axis_tready;
    ml_d    = ml_q;
    mh_d    = mh_q;
    ms_d    = ms_q;
    finish  = 1'b0;
    r0f     = '0;
    r1f     = '0;
    wr.en   = 1'b0;
    wr.pos  = lp_q[PosW-1:0];
    wr.sym  = sym4;
    wr.ckpt = {tot_q[3][CkFldW-1:0], tot_q[2][CkFldW-1:0],
               tot_q[1][CkFldW-1:0], tot_q[0][CkFldW-1:0]};
    req.valid = 1'b0;
    req.n     = x0[PosW-1:0];
    req.c     = sym[1:0];

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (s_axis_tuser[0] == OpLoad) begin
            if (!lp_q[PosW]) begin
              wr.en = 1'b1;
              tot_d[sym4] = tot_q[sym4] + CntW'(1);
              lp_d = lp_q + CntW'(1);
            end
          end else if (s_axis_tuser[1]) begin
            finish = 1'b1;
            fail_d = StMatch;
            if (sym >= SymOther) begin
              fail_d = StInvalid;
            end else if (base[sym] == base[sym+1]) begin
              fail_d = StNoOcc;
            end else begin
              low_d  = base[sym];
              high_d = base[sym+1] - PosW'(1);
            end
          end else if (fail_q != StMatch) begin
            finish = 1'b1;
          end else if (sym >= SymOther) begin
            finish = 1'b1;
            fail_d = StInvalid;
          end else begin
            req.valid = 1'b1;
            c_d    = sym[1:0];
            use0_d = !(x0 < lp_q);
            use1_d = !(x1 < lp_q);
            n1_d   = x1[PosW-1:0];
            state_d = S_REQ1;
          end
        end
      end
      S_REQ1: begin
        req.valid = 1'b1;
        req.n     = n1_q;
        req.c     = c_q;
        state_d   = S_WAIT;
      end
      S_WAIT: state_d = S_CAP0;
      S_CAP0: begin
        r0_d    = rank;
        state_d = S_CAP1;
      end
      S_CAP1: begin
        r0f = use0_q ? tot_q[c_q] : r0_q;
        r1f = use1_q ? tot_q[c_q] : rank;
        if (c_q == 2'd0) begin
          if (lo1 > {1'b0, pp_q}) begin
            r0f = r0f - CntW'(1);
            r1f = r1f - CntW'(1);
          end else if (hi1 >= {1'b0, pp_q}) begin
            r1f = r1f - CntW'(1);
          end
        end
        if (r0f == r1f) begin
          fail_d = StNoOcc;
        end else begin
          low_d  = base[c_q] + r0f[PosW-1:0];
          high_d = base[c_q] + r1f[PosW-1:0] - PosW'(1);
        end
        finish  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // result beat
    if (finish) begin
      mv_d = 1'b1;
      if (fail_d == StMatch) begin
        ml_d = low_d;
        mh_d = high_d;
        ms_d = StMatch;
      end else begin
        ml_d = '0;
        mh_d = '0;
        ms_d = fail_d;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int k = 0; k < 5; k++) tot_q[k] <= '0;
      lp_q    <= '0;
      low_q   <= '0;
      high_q  <= '0;
      fail_q  <= StMatch;
      pp_q    <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      tot_q   <= tot_d;
      lp_q    <= lp_d;
      low_q   <= low_d;
      high_q  <= high_d;
      fail_q  <= fail_d;
      mv_q    <= mv_d;
      if (cfg_we_i) pp_q <= cfg_wdata_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    n1_q   <= n1_d;
    use0_q <= use0_d;
    use1_q <= use1_d;
    r0_q   <= r0_d;
    ml_q   <= ml_d;
    mh_q   <= mh_d;
    ms_q   <= ms_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {6'd0, ms_q, mh_q, ml_q};

endmodule
`default_nettype wire
